### rtl/mcfir_pkg.sv
// Shared types, codes and field widths of the multichannel FIR filter core.
`default_nettype none

package mcfir_pkg;

	// Field widths of one transfer on each channel.
	localparam int CMD_W    = 2;
	localparam int SENSOR_W = 3;
	localparam int KERNEL_W = 4;
	localparam int TAP_W    = 5;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 6;

	// Q1.15 coefficients: the accumulator is shifted right by this amount.
	localparam int FRAC_BITS = 15;

	// Default sizes of the storage.
	localparam int DEF_NUM_CHANNELS  = 8;
	localparam int DEF_HISTORY_DEPTH = 32;
	localparam int DEF_NUM_KERNELS   = 16;

	// Command codes of an input item.
	localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LEN    = 2'd2;

	// Saturation limits of the result.
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	// What a latched item asks for once its fields have been checked.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_COEF,
		KIND_LEN,
		KIND_FILT
	} item_kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_UPDATE,
		S_MAC,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;
		logic load;
		logic wr_coef;
		logic wr_len;
		logic update;
		logic mac_run;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       clr_done;
		item_kind_t kind;
		logic       mac_done;
		logic       out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

### rtl/mcfir_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mcfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/mcfir_ctrl.sv
// Controller state machine of the multichannel FIR filter core.
`default_nettype none

module mcfir_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output mcfir_pkg::ctrl_cmd_t  ctl,
	input  mcfir_pkg::ctrl_stat_t sts
);

	import mcfir_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.kind == KIND_FILT) begin
					state_d = S_UPDATE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UPDATE: begin
				state_d = S_MAC;
			end
			S_MAC: begin
				if (sts.mac_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr_en = 1'b1;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			S_DECODE: begin
				ctl.wr_coef = (sts.kind == KIND_COEF);
				ctl.wr_len  = (sts.kind == KIND_LEN);
			end
			S_UPDATE: begin
				ctl.update = 1'b1;
			end
			S_MAC: begin
				ctl.mac_run = 1'b1;
			end
			S_DONE: begin
				ctl.finish = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

`ifndef SYNTH
	// The clearing sweep runs once after reset and is never entered again.
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |=> state_q != S_CLEAR)
		else $error("clear sweep entered after it had finished");

	// At most one datapath command is active in any cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.clr_en, ctl.load, ctl.wr_coef, ctl.wr_len, ctl.update, ctl.mac_run,
			ctl.finish}))
		else $error("more than one datapath command active");
`endif

endmodule

`default_nettype wire

### rtl/mcfir_dp.sv
// Datapath of the multichannel FIR filter core: memories, shared MAC and output register.
`default_nettype none

module mcfir_dp #(
	parameter int NUM_CHANNELS  = mcfir_pkg::DEF_NUM_CHANNELS,
	parameter int HISTORY_DEPTH = mcfir_pkg::DEF_HISTORY_DEPTH,
	parameter int NUM_KERNELS   = mcfir_pkg::DEF_NUM_KERNELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcfir_pkg::ctrl_cmd_t                ctl,
	output mcfir_pkg::ctrl_stat_t               sts,
	input  logic [mcfir_pkg::CMD_W-1:0]         cmd,
	input  logic [mcfir_pkg::SENSOR_W-1:0]      sensor,
	input  logic [mcfir_pkg::KERNEL_W-1:0]      kernel,
	input  logic [mcfir_pkg::TAP_W-1:0]         tap,
	input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_or_coef,
	input  logic [mcfir_pkg::COUNT_W-1:0]       tap_count,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [mcfir_pkg::SAMPLE_W-1:0] filtered,
	output logic                                clipped
);

	import mcfir_pkg::*;

	localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int KN_W    = (NUM_KERNELS > 1) ? $clog2(NUM_KERNELS) : 1;
	localparam int PTR_W   = $clog2(HISTORY_DEPTH);
	localparam int LEN_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int H_DEPTH = 1 << (CH_W + PTR_W);
	localparam int C_DEPTH = 1 << (KN_W + PTR_W);
	localparam int H_AW    = CH_W + PTR_W;
	localparam int C_AW    = KN_W + PTR_W;
	localparam int CLR_LEN = (H_DEPTH > NUM_KERNELS) ? H_DEPTH : NUM_KERNELS;
	localparam int CLR_W   = $clog2(CLR_LEN);
	localparam int PROD_W  = 2 * SAMPLE_W;
	localparam int ACC_W   = PROD_W + LEN_W;

	// Latched item.
	logic [CMD_W-1:0]           cmd_q;
	logic [SENSOR_W-1:0]        sensor_q;
	logic [KERNEL_W-1:0]        kernel_q;
	logic [TAP_W-1:0]           tap_q;
	logic signed [SAMPLE_W-1:0] val_q;
	logic [COUNT_W-1:0]         count_q;

	logic [CLR_W-1:0]           clr_addr_q;
	logic [PTR_W-1:0]           pos_q;
	logic [PTR_W-1:0]           k_q;
	logic [LEN_W-1:0]           remain_q;
	logic                       vld_s1_q;
	logic                       vld_s2_q;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic                       clipped_q;

	logic [CH_W-1:0]  ch_idx;
	logic [KN_W-1:0]  kn_idx;
	logic [PTR_W-1:0] tap_idx;
	logic             kern_ok;
	logic             chan_ok;
	logic             tap_ok;
	item_kind_t       kind;
	logic [LEN_W-1:0] len_clamped;

	logic             h_we;
	logic [H_AW-1:0]  h_waddr;
	logic [SAMPLE_W-1:0] h_wdata;
	logic [SAMPLE_W-1:0] h_rdata;
	logic [SAMPLE_W-1:0] c_rdata;
	logic             p_we;
	logic [CH_W-1:0]  p_waddr;
	logic [PTR_W-1:0] p_wdata;
	logic [PTR_W-1:0] p_rdata;
	logic             l_we;
	logic [KN_W-1:0]  l_waddr;
	logic [LEN_W-1:0] l_wdata;
	logic [LEN_W-1:0] l_rdata;

	logic [PTR_W-1:0] ptr_new;
	logic             issue;
	logic             clr_last;
	logic signed [SAMPLE_W-1:0] hist_rd;
	logic signed [SAMPLE_W-1:0] coef_rd;
	logic signed [ACC_W-1:0]    shifted;
	logic [ACC_W-SAMPLE_W:0]    hi_bits;
	logic                       ovf;
	logic signed [SAMPLE_W-1:0] sat_val;

	// Field checks of the latched item.
	assign ch_idx  = CH_W'(sensor_q);
	assign kn_idx  = KN_W'(kernel_q);
	assign tap_idx = PTR_W'(tap_q);
	assign kern_ok = 32'(kernel_q) < NUM_KERNELS;
	assign chan_ok = 32'(sensor_q) < NUM_CHANNELS;
	assign tap_ok  = 32'(tap_q) < HISTORY_DEPTH;

	always_comb begin
		kind = KIND_NONE;
		if (kern_ok) begin
			case (cmd_q)
				CMD_FILTER: kind = chan_ok ? KIND_FILT : KIND_NONE;
				CMD_COEF:   kind = tap_ok ? KIND_COEF : KIND_NONE;
				CMD_LEN:    kind = KIND_LEN;
				default:    kind = KIND_NONE;
			endcase
		end
	end

	assign len_clamped = (32'(count_q) > HISTORY_DEPTH) ? LEN_W'(HISTORY_DEPTH)
		: LEN_W'(count_q);

	assign ptr_new = (p_rdata == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p_rdata + 1'b1;
	assign issue   = ctl.mac_run && (remain_q != '0);
	assign clr_last = (clr_addr_q == CLR_W'(CLR_LEN - 1));

	// Write ports: the clearing sweep writes zeros, otherwise the item writes.
	assign h_we    = (ctl.clr_en && (32'(clr_addr_q) < H_DEPTH)) || ctl.update;
	assign h_waddr = ctl.clr_en ? H_AW'(clr_addr_q) : {ch_idx, ptr_new};
	assign h_wdata = ctl.clr_en ? '0 : val_q;
	assign p_we    = (ctl.clr_en && (32'(clr_addr_q) < NUM_CHANNELS)) || ctl.update;
	assign p_waddr = ctl.clr_en ? CH_W'(clr_addr_q) : ch_idx;
	assign p_wdata = ctl.clr_en ? '0 : ptr_new;
	assign l_we    = (ctl.clr_en && (32'(clr_addr_q) < NUM_KERNELS)) || ctl.wr_len;
	assign l_waddr = ctl.clr_en ? KN_W'(clr_addr_q) : kn_idx;
	assign l_wdata = ctl.clr_en ? '0 : len_clamped;

	mcfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(H_DEPTH)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr ({ch_idx, pos_q}),
		.rdata (h_rdata)
	);

	mcfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(C_DEPTH)) u_coef (
		.clk   (clk),
		.we    (ctl.wr_coef),
		.waddr ({kn_idx, tap_idx}),
		.wdata (val_q),
		.raddr ({kn_idx, k_q}),
		.rdata (c_rdata)
	);

	mcfir_ram #(.WIDTH(PTR_W), .DEPTH(NUM_CHANNELS)) u_ptr (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (ch_idx),
		.rdata (p_rdata)
	);

	mcfir_ram #(.WIDTH(LEN_W), .DEPTH(NUM_KERNELS)) u_len (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (kn_idx),
		.rdata (l_rdata)
	);

	assign hist_rd = h_rdata;
	assign coef_rd = c_rdata;

	// Floor shift and saturation of the finished sum.
	assign shifted = acc_q >>> FRAC_BITS;
	assign hi_bits = shifted[ACC_W-1:SAMPLE_W-1];
	assign ovf     = !((&hi_bits) || (~|hi_bits));
	assign sat_val = ovf ? (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX) : shifted[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			remain_q    <= '0;
			vld_s1_q    <= 1'b0;
			vld_s2_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_en && !clr_last) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (ctl.update) begin
				remain_q <= l_rdata;
			end else if (issue) begin
				remain_q <= remain_q - 1'b1;
			end
			vld_s1_q <= issue;
			vld_s2_q <= vld_s1_q;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			sensor_q <= sensor;
			kernel_q <= kernel;
			tap_q    <= tap;
			val_q    <= sample_or_coef;
			count_q  <= tap_count;
		end
		if (ctl.update) begin
			pos_q <= ptr_new;
			k_q   <= PTR_W'(l_rdata - 1'b1);
			acc_q <= '0;
		end else begin
			if (issue) begin
				pos_q <= (pos_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : pos_q - 1'b1;
				k_q   <= k_q - 1'b1;
			end
			if (vld_s2_q) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		prod_s2 <= PROD_W'(hist_rd) * PROD_W'(coef_rd);
		if (ctl.finish) begin
			filtered_q <= sat_val;
			clipped_q  <= ovf;
		end
	end

	assign sts.clr_done = clr_last;
	assign sts.kind     = kind;
	assign sts.mac_done = (remain_q == '0) && !vld_s1_q && !vld_s2_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign clipped   = clipped_q;

`ifndef SYNTH
	// A product only enters the accumulator in the cycle after its memory read data arrives.
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2_q |-> $past(vld_s1_q))
		else $error("product valid without a read the cycle before");

	// A result is never taken while taps are still in flight.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> (remain_q == '0) && !vld_s1_q && !vld_s2_q)
		else $error("result loaded before the MAC pipeline drained");

	// A clipped result holds one of the two saturation limits.
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clipped_q |-> (filtered_q == SAT_MAX || filtered_q == SAT_MIN))
		else $error("clipped result is not a saturation limit");
`endif

endmodule

`default_nettype wire

### rtl/multichannel_fir_filter_core.sv
// Top level of the multichannel FIR filter core with a loadable kernel bank.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   input   | in        | in_valid/in_ready  | cmd, sensor, kernel, tap, sample_or_coef,
//           |           |                    | tap_count
//   output  | out       | out_valid/out_ready| filtered, clipped
//
// A filter item with a tap count of L of one or more goes from its transfer to the next
// possible input transfer through these steps: check the fields and read the channel's
// ring pointer and kernel length, store the sample, run L taps through the single
// shared multiply-accumulate (one history and one coefficient memory read per tap),
// drain its pipeline, load the result register once the output register is free, and
// return to idle with in_ready high. With a tap count of zero no tap is issued.
// Coefficient and tap count writes give no result.
// After reset the history rings, ring pointers and tap counts are swept to zero, one
// entry a cycle, over max(2**(clog2(NUM_CHANNELS) + clog2(HISTORY_DEPTH)), NUM_KERNELS)
// addresses (256 at the default sizes); in_ready stays low during the sweep.
// A result waits in the output register while the next item is accepted; only when
// a second result is ready before the first transfer has happened does the core hold.
`default_nettype none

module multichannel_fir_filter_core #(
	parameter int NUM_CHANNELS  = mcfir_pkg::DEF_NUM_CHANNELS,
	parameter int HISTORY_DEPTH = mcfir_pkg::DEF_HISTORY_DEPTH,
	parameter int NUM_KERNELS   = mcfir_pkg::DEF_NUM_KERNELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mcfir_pkg::CMD_W-1:0]           cmd,
	input  logic [mcfir_pkg::SENSOR_W-1:0]        sensor,
	input  logic [mcfir_pkg::KERNEL_W-1:0]        kernel,
	input  logic [mcfir_pkg::TAP_W-1:0]           tap,
	input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_or_coef,
	input  logic [mcfir_pkg::COUNT_W-1:0]         tap_count,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mcfir_pkg::SAMPLE_W-1:0] filtered,
	output logic                                  clipped
);

	import mcfir_pkg::*;

	// Commands and status between the controller and the datapath.
	ctrl_cmd_t  ctl;
	ctrl_stat_t sts;

	// The controller sequences the clearing sweep, the decode of each item and the
	// multiply-accumulate loop; it never touches the payload.
	mcfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// The datapath holds the latched item, all four memories, the shared MAC with
	// its read and product stages, the saturation logic and the output register.
	mcfir_dp #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.NUM_KERNELS   (NUM_KERNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cmd            (cmd),
		.sensor         (sensor),
		.kernel         (kernel),
		.tap            (tap),
		.sample_or_coef (sample_or_coef),
		.tap_count      (tap_count),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.filtered       (filtered),
		.clipped        (clipped)
	);

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench of the multichannel FIR filter core with a loadable kernel bank.
`default_nettype none

module tb;
	import mcfir_pkg::*;

	// The bench runs the core at its default sizes.
	localparam int N_CHANNELS = DEF_NUM_CHANNELS;
	localparam int DEPTH      = DEF_HISTORY_DEPTH;
	localparam int N_KERNELS  = DEF_NUM_KERNELS;

	// The fourth command code has no meaning and the core must drop it silently.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// This margin covers the longest filter item, of 32 taps, still in flight.
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_REPORTS = 10;

	// One input transfer, with the same fields as the input ports.
	typedef struct {
		logic [CMD_W-1:0]           cmd;
		logic [SENSOR_W-1:0]        sensor;
		logic [KERNEL_W-1:0]        kernel;
		logic [TAP_W-1:0]           tap;
		logic signed [SAMPLE_W-1:0] sample_or_coef;
		logic [COUNT_W-1:0]         tap_count;
	} fir_item_t;

	// One output transfer.
	typedef struct {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       clipped;
	} fir_result_t;

	logic clk;
	logic arst_n = 1'b0;

	// All inputs of the core hold known values from time zero on.
	logic                       in_valid       = 1'b0;
	logic [CMD_W-1:0]           cmd            = '0;
	logic [SENSOR_W-1:0]        sensor         = '0;
	logic [KERNEL_W-1:0]        kernel         = '0;
	logic [TAP_W-1:0]           tap            = '0;
	logic signed [SAMPLE_W-1:0] sample_or_coef = '0;
	logic [COUNT_W-1:0]         tap_count      = '0;
	logic                       out_ready      = 1'b0;
	logic                       in_ready;
	logic                       out_valid;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       clipped;

	// Idle percentages of the two sides; the stimulus tasks change them per phase.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Mirror of the core's state, updated at every accepted input transfer.
	logic signed [SAMPLE_W-1:0] sample_history [N_CHANNELS][DEPTH] = '{default: '0};
	int unsigned                ring_ptr       [N_CHANNELS]        = '{default: 0};
	logic signed [SAMPLE_W-1:0] coef_bank      [N_KERNELS][DEPTH]  = '{default: '0};
	logic [DEPTH-1:0]           coef_loaded    [N_KERNELS]         = '{default: '0};
	int unsigned                kernel_taps    [N_KERNELS]         = '{default: 0};

	// Filter outputs that the core still owes, oldest first.
	fir_result_t expected_outputs[$];
	fir_result_t head;

	int failures        = 0;
	int transfers_sent  = 0;
	int results_checked = 0;
	int clipped_seen    = 0;

	multichannel_fir_filter_core #(
		.NUM_CHANNELS (N_CHANNELS),
		.HISTORY_DEPTH(DEPTH),
		.NUM_KERNELS  (N_KERNELS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.sensor        (sensor),
		.kernel        (kernel),
		.tap           (tap),
		.sample_or_coef(sample_or_coef),
		.tap_count     (tap_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.filtered      (filtered),
		.clipped       (clipped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Counts a failure and prints only the first few, so a broken core does not flood the log.
	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	// Applies one accepted input transfer to the mirrored state and works out the filter
	// output it causes. Out-of-range fields and the unused command leave everything as is.
	function automatic void compute_fir_response(input fir_item_t it, output bit produces,
			output fir_result_t res);
		int unsigned ch;
		int unsigned kn;
		int unsigned ptr;
		int unsigned len;
		int unsigned pos;
		longint acc;
		longint q;
		produces     = 1'b0;
		res.filtered = '0;
		res.clipped  = 1'b0;
		ch           = it.sensor;
		kn           = it.kernel;
		if (kn >= N_KERNELS) begin
			return;
		end
		case (it.cmd)
			CMD_COEF: begin
				if (it.tap < DEPTH) begin
					coef_bank[kn][it.tap]   = it.sample_or_coef;
					coef_loaded[kn][it.tap] = 1'b1;
				end
			end
			CMD_LEN: begin
				// A tap count beyond the history depth is clamped to it.
				kernel_taps[kn] = (it.tap_count > DEPTH) ? DEPTH : it.tap_count;
			end
			CMD_FILTER: begin
				if (ch < N_CHANNELS) begin
					// The pointer moves first, so the first sample after reset lands at one.
					ptr                     = (ring_ptr[ch] + 1 >= DEPTH) ? 0 : ring_ptr[ch] + 1;
					ring_ptr[ch]            = ptr;
					sample_history[ch][ptr] = it.sample_or_coef;
					// The newest sample meets the kernel's last coefficient.
					len = kernel_taps[kn];
					acc = 0;
					pos = ptr;
					for (int i = 0; i < len; i++) begin
						acc += longint'(coef_bank[kn][len - 1 - i]) *
							longint'(sample_history[ch][pos]);
						pos = (pos == 0) ? DEPTH - 1 : pos - 1;
					end
					// Arithmetic shift rounds toward minus infinity.
					q = acc >>> FRAC_BITS;
					if (q > longint'(SAT_MAX)) begin
						res.filtered = SAT_MAX;
						res.clipped  = 1'b1;
					end else if (q < longint'(SAT_MIN)) begin
						res.filtered = SAT_MIN;
						res.clipped  = 1'b1;
					end else begin
						res.filtered = SAMPLE_W'(q);
					end
					produces = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Returns the lowest coefficient position that the kernel uses but that was never
	// loaded, or -1 when the kernel can be filtered with.
	function automatic int first_missing_tap(input int unsigned kn);
		for (int t = 0; t < kernel_taps[kn]; t++) begin
			if (!coef_loaded[kn][t]) begin
				return t;
			end
		end
		return -1;
	endfunction

	function automatic fir_item_t make_item(input logic [CMD_W-1:0] c, input int s,
			input int k, input int t, input int v, input int n);
		fir_item_t it;
		it.cmd            = c;
		it.sensor         = SENSOR_W'(s);
		it.kernel         = KERNEL_W'(k);
		it.tap            = TAP_W'(t);
		it.sample_or_coef = SAMPLE_W'(v);
		it.tap_count      = COUNT_W'(n);
		return it;
	endfunction

	// Samples and coefficients lean toward the extremes and toward small values, so that
	// both saturated and in-range outputs turn up often.
	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return SAT_MIN;
			1:       return SAT_MAX;
			2, 3, 4: return SAMPLE_W'($urandom_range(0, 511) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Mostly legal tap counts, short ones often, and now and then one that needs clamping.
	function automatic logic [COUNT_W-1:0] pick_tap_count();
		case ($urandom_range(0, 3))
			0:       return COUNT_W'($urandom_range(0, 8));
			3:       return COUNT_W'($urandom_range(0, 63));
			default: return COUNT_W'($urandom_range(0, DEPTH));
		endcase
	endfunction

	// Presents one item after a random idle gap, holds it until the transfer happens and
	// then records what the core should answer.
	task automatic send_transfer(input fir_item_t it);
		fir_result_t want;
		bit          produces;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= it.cmd;
		sensor         <= it.sensor;
		kernel         <= it.kernel;
		tap            <= it.tap;
		sample_or_coef <= it.sample_or_coef;
		tap_count      <= it.tap_count;
		do @(posedge clk); while (in_ready !== 1'b1);
		compute_fir_response(it, produces, want);
		if (produces) begin
			expected_outputs.push_back(want);
		end
		transfers_sent++;
	endtask

	// Holds the input side quiet until the core has delivered every owed output. It always
	// waits on a clock edge before checking, so in_valid is never lowered and raised in the same step.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_outputs.size() != 0);
	endtask

	// The receiver decides afresh at every edge whether it takes an output.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Every output transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) begin
			if (expected_outputs.size() == 0) begin
				note_failure($sformatf("output transfer filtered=%0d clipped=%0b with none owed",
					filtered, clipped));
			end else begin
				head = expected_outputs.pop_front();
				results_checked++;
				if (head.clipped) begin
					clipped_seen++;
				end
				if (filtered !== head.filtered || clipped !== head.clipped) begin
					note_failure($sformatf(
						"output mismatch: expected filtered=%0d clipped=%0b, got filtered=%0d clipped=%0b",
						head.filtered, head.clipped, filtered, clipped));
				end
			end
		end
	end

	// Right after reset every tap count is zero, so any kernel filters to zero while the
	// sample still lands in the ring. A tap count written as zero behaves the same way.
	task automatic test_zero_length_kernel();
		send_transfer(make_item(CMD_FILTER, 0, 0, 0, 32767, 0));
		send_transfer(make_item(CMD_FILTER, 7, 15, 31, -32768, 63));
		send_transfer(make_item(CMD_LEN, 3, 4, 0, 0, 0));
		send_transfer(make_item(CMD_FILTER, 3, 4, 17, -1, 0));
	endtask

	// A two-tap kernel of minus one drives the accumulator past both limits, and a one-tap
	// kernel of the smallest positive coefficient shows the rounding of negative sums.
	task automatic test_saturation();
		send_transfer(make_item(CMD_COEF, 0, 2, 0, -32768, 0));
		send_transfer(make_item(CMD_COEF, 0, 2, 1, -32768, 0));
		send_transfer(make_item(CMD_LEN, 0, 2, 0, 0, 2));
		send_transfer(make_item(CMD_FILTER, 1, 2, 0, -32768, 0));
		send_transfer(make_item(CMD_FILTER, 1, 2, 0, -32768, 0));
		send_transfer(make_item(CMD_FILTER, 1, 2, 0, 32767, 0));
		send_transfer(make_item(CMD_FILTER, 1, 2, 0, 32767, 0));
		send_transfer(make_item(CMD_COEF, 0, 2, 1, 32767, 0));
		send_transfer(make_item(CMD_FILTER, 1, 2, 0, 1, 0));
		send_transfer(make_item(CMD_COEF, 0, 3, 0, 1, 0));
		send_transfer(make_item(CMD_LEN, 0, 3, 0, 0, 1));
		send_transfer(make_item(CMD_FILTER, 2, 3, 0, -1, 0));
		send_transfer(make_item(CMD_FILTER, 2, 3, 0, 1, 0));
	endtask

	// The unused command with every field at its top, the last coefficient slot, and tap
	// counts at, just above and far above the history depth. The random part later fills
	// the long kernels and filters with them.
	task automatic test_write_corners();
		send_transfer(make_item(CMD_UNUSED, 7, 15, 31, -1, 63));
		send_transfer(make_item(CMD_COEF, 5, 15, 31, 16'h5555, 63));
		send_transfer(make_item(CMD_LEN, 6, 15, 31, -1, 63));
		send_transfer(make_item(CMD_LEN, 0, 14, 0, 0, 32));
		send_transfer(make_item(CMD_LEN, 0, 13, 0, 0, 33));
		send_transfer(make_item(CMD_FILTER, 4, 2, 0, 0, 0));
	endtask

	// Random traffic, mostly filter items. A filter item aimed at a kernel with a missing
	// coefficient turns into a write of that coefficient, so kernels fill up and long
	// convolutions follow. Every so often the sender waits for all owed outputs.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
		fir_item_t it;
		int        done_items;
		int        roll;
		int        missing;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		done_items    = 0;
		while (done_items < n_items) begin
			it.cmd            = CMD_FILTER;
			it.sensor         = SENSOR_W'($urandom_range(0, N_CHANNELS - 1));
			it.kernel         = KERNEL_W'($urandom_range(0, N_KERNELS - 1));
			it.tap            = TAP_W'($urandom_range(0, DEPTH - 1));
			it.sample_or_coef = pick_value();
			it.tap_count      = COUNT_W'($urandom_range(0, 63));
			roll              = $urandom_range(0, 99);
			if (roll < 4) begin
				it.cmd = CMD_UNUSED;
			end else if (roll < 24) begin
				it.cmd = CMD_COEF;
			end else if (roll < 32) begin
				it.cmd       = CMD_LEN;
				it.tap_count = pick_tap_count();
			end else begin
				missing = first_missing_tap(it.kernel);
				if (missing >= 0) begin
					it.cmd = CMD_COEF;
					it.tap = TAP_W'(missing);
				end
			end
			send_transfer(it);
			// Dropped items do not count toward the length of the phase.
			if (it.cmd != CMD_UNUSED) begin
				done_items++;
				if (done_items % 199 == 198) begin
					wait_results_drained();
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		recv_idle_pct = 20;
		test_zero_length_kernel();
		test_saturation();
		test_write_corners();

		// Slow receiver, then slow sender, then both at full rate.
		test_random_traffic(6, 73, 550);
		test_random_traffic(73, 6, 550);
		test_random_traffic(0, 0, 550);

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input transfers over directed corners and three idle mixes.",
			transfers_sent);
		$display("Checked %0d filter outputs, %0d of them saturated; %0d failures.",
			results_checked, clipped_seen, failures);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// A hung handshake ends the run here; a correct run needs well under a tenth of this.
	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
